// ----- sv/wscd_pkg.sv -----
package wscd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0   = 3'd0,
        PH_HDR1   = 3'd1,
        PH_EXT16  = 3'd2,
        PH_EXT64  = 3'd3,
        PH_MASK   = 3'd4,
        PH_DATA   = 3'd5,
        PH_CLOSED = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE          = 3'd0,
        ERR_UNMASKED      = 3'd1,
        ERR_FRAME_SIZE    = 3'd2,
        ERR_CTRL_FRAG     = 3'd3,
        ERR_CTRL_SIZE     = 3'd4,
        ERR_MSG_SIZE      = 3'd5,
        ERR_STRAY_CONT    = 3'd6
    } err_t;

    localparam logic [0:0] CFG_MAX_FRAME   = 1'd0;
    localparam logic [0:0] CFG_MAX_MESSAGE = 1'd1;

    localparam logic [31:0] MAX_FRAME_RESET   = 32'd1048576;
    localparam logic [31:0] MAX_MESSAGE_RESET = 32'd4194304;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_CLOSE = 4'h8;

    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;
    localparam logic [31:0] CTRL_MAX_LEN = 32'd125;

    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] MASK_LAST  = 3'd3;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        logic [3:0] frame_opcode;
        logic [3:0] message_opcode;
        logic       end_of_frame;
        logic       end_of_message;
        err_t       error_code;
    } result_t;

endpackage

// ----- sv/wscd_core.sv -----
module wscd_core
    import wscd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] max_frame_bytes,
    input  logic [31:0] max_message_bytes,
    output logic        res_valid,
    output result_t     res
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  idx_reg, idx_next;
    logic        fin_reg, fin_next;
    logic [3:0]  op_reg, op_next;
    logic [31:0] left_reg, left_next;
    logic        big_reg, big_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  mpos_reg, mpos_next;
    logic        started_reg, started_next;
    logic [3:0]  sop_reg, sop_next;
    logic [31:0] total_reg, total_next;

    logic        ctrl;
    logic [32:0] msg_sum;
    logic [31:0] left_dec;
    logic [7:0]  key_byte;
    logic        len_done;

    assign ctrl = op_reg[3];
    assign msg_sum = {1'b0, total_reg} + {1'b0, left_reg};
    assign left_dec = (left_reg != 32'd0) ? left_reg - 32'd1 : 32'd0;

    always_comb
    begin
        unique case (mpos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        fin_next     = fin_reg;
        op_next      = op_reg;
        left_next    = left_reg;
        big_next     = big_reg;
        key_next     = key_reg;
        mpos_next    = mpos_reg;
        started_next = started_reg;
        sop_next     = sop_reg;
        total_next   = total_reg;
        len_done     = 1'b0;
        res_valid    = 1'b0;
        res          = '0;
        res.frame_opcode = op_reg;

        unique case (phase_reg)
            PH_HDR0:
            begin
                fin_next   = rx_byte[7];
                op_next    = rx_byte[3:0];
                phase_next = PH_HDR1;
            end
            PH_HDR1:
            begin
                if (!rx_byte[7])
                begin
                    phase_next     = PH_CLOSED;
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_UNMASKED;
                end
                else
                begin
                    left_next = {25'd0, rx_byte[6:0]};
                    big_next  = 1'b0;
                    idx_next  = 3'd0;
                    if (rx_byte[6:0] == LEN_EXT16)
                    begin
                        left_next  = 32'd0;
                        phase_next = PH_EXT16;
                    end
                    else if (rx_byte[6:0] == LEN_EXT64)
                    begin
                        left_next  = 32'd0;
                        phase_next = PH_EXT64;
                    end
                    else
                    begin
                        len_done = 1'b1;
                    end
                end
            end
            PH_EXT16, PH_EXT64:
            begin
                big_next  = big_reg | (left_reg[31:24] != 8'd0);
                left_next = {left_reg[23:0], rx_byte};
                if (idx_reg == ((phase_reg == PH_EXT16) ? EXT16_LAST : EXT64_LAST))
                begin
                    len_done = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            PH_MASK:
            begin
                key_next = {key_reg[23:0], rx_byte};
                if (idx_reg >= MASK_LAST)
                begin
                    if (ctrl && !fin_reg)
                    begin
                        phase_next     = PH_CLOSED;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_CTRL_FRAG;
                    end
                    else if (ctrl && left_reg > CTRL_MAX_LEN)
                    begin
                        phase_next     = PH_CLOSED;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_CTRL_SIZE;
                    end
                    else if (!ctrl && op_reg == OP_CONT && !started_reg)
                    begin
                        phase_next     = PH_CLOSED;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_STRAY_CONT;
                    end
                    else if (!ctrl && op_reg == OP_CONT &&
                             msg_sum > {1'b0, max_message_bytes})
                    begin
                        phase_next     = PH_CLOSED;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_MSG_SIZE;
                    end
                    else
                    begin
                        if (!ctrl)
                        begin
                            if (op_reg != OP_CONT)
                            begin
                                started_next = 1'b1;
                                sop_next     = op_reg;
                                total_next   = left_reg;
                            end
                            else
                            begin
                                total_next = msg_sum[31:0];
                            end
                        end
                        mpos_next = 2'd0;
                        if (left_reg == 32'd0)
                        begin
                            res_valid          = 1'b1;
                            res.kind           = KIND_EMPTY;
                            res.message_opcode = ctrl ? op_reg : sop_next;
                            res.end_of_frame   = 1'b1;
                            phase_next         = PH_HDR0;
                            if (ctrl)
                            begin
                                if (op_reg == OP_CLOSE)
                                begin
                                    phase_next = PH_CLOSED;
                                end
                            end
                            else if (fin_reg)
                            begin
                                res.end_of_message = 1'b1;
                                started_next       = 1'b0;
                                total_next         = 32'd0;
                            end
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            PH_DATA:
            begin
                res_valid          = 1'b1;
                res.kind           = KIND_PAYLOAD;
                res.payload_byte   = rx_byte ^ key_byte;
                res.message_opcode = ctrl ? op_reg : sop_reg;
                mpos_next          = mpos_reg + 2'd1;
                left_next          = left_dec;
                if (left_dec == 32'd0)
                begin
                    res.end_of_frame = 1'b1;
                    phase_next       = PH_HDR0;
                    if (ctrl)
                    begin
                        if (op_reg == OP_CLOSE)
                        begin
                            phase_next = PH_CLOSED;
                        end
                    end
                    else if (fin_reg)
                    begin
                        res.end_of_message = 1'b1;
                        started_next       = 1'b0;
                        total_next         = 32'd0;
                    end
                end
            end
            default:
            begin
                phase_next = PH_CLOSED;
            end
        endcase

        // length complete: frame limit check, then mask key
        if (len_done)
        begin
            if (big_next || left_next > max_frame_bytes)
            begin
                phase_next     = PH_CLOSED;
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_FRAME_SIZE;
            end
            else
            begin
                phase_next = PH_MASK;
                idx_next   = 3'd0;
                key_next   = 32'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            idx_reg     <= 3'd0;
            fin_reg     <= 1'b0;
            op_reg      <= 4'd0;
            left_reg    <= 32'd0;
            big_reg     <= 1'b0;
            key_reg     <= 32'd0;
            mpos_reg    <= 2'd0;
            started_reg <= 1'b0;
            sop_reg     <= 4'd0;
            total_reg   <= 32'd0;
        end
        else if (go)
        begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            fin_reg     <= fin_next;
            op_reg      <= op_next;
            left_reg    <= left_next;
            big_reg     <= big_next;
            key_reg     <= key_next;
            mpos_reg    <= mpos_next;
            started_reg <= started_next;
            sop_reg     <= sop_next;
            total_reg   <= total_next;
        end
    end

endmodule

// ----- sv/wscd_out_reg.sv -----
module wscd_out_reg
    import wscd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    go,
    input  logic    res_valid,
    input  result_t res,
    input  logic    out_stall,
    output logic    busy,
    output logic    out_valid,
    output result_t out_res
);

    logic    valid_reg;
    result_t data_reg;
    logic    load;

    assign busy      = valid_reg & out_stall;
    assign load      = !busy;
    assign out_valid = valid_reg;
    assign out_res   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= go & res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && go && res_valid)
        begin
            data_reg <= res;
        end
    end

endmodule

// ----- sv/websocket_client_frame_decoder.sv -----
// Client frame decoder: one received byte per request, at most one result per request.
// The result is registered: it is valid in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; bytes stall only while a result is held by out_stall.
// Reset (rst_n, async low): parser waits for a header, no message open, limits at
// 1 MiB per frame and 4 MiB per message. An error or a finished close frame drops
// every later byte until the next reset.
module websocket_client_frame_decoder
    import wscd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  out_kind,
    output logic [7:0]  payload_byte,
    output logic [3:0]  frame_opcode,
    output logic [3:0]  message_opcode,
    output logic        end_of_frame,
    output logic        end_of_message,
    output logic [2:0]  error_code
);

    logic [31:0] max_frame_reg;
    logic [31:0] max_message_reg;
    logic        go;
    logic        busy;
    logic        res_valid;
    result_t     res;
    result_t     out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg   <= MAX_FRAME_RESET;
            max_message_reg <= MAX_MESSAGE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_FRAME:   max_frame_reg   <= cfg_data;
                CFG_MAX_MESSAGE: max_message_reg <= cfg_data;
                default:         max_frame_reg   <= max_frame_reg;
            endcase
        end
    end

    assign in_stall = busy;
    assign go       = in_valid & !busy;

    wscd_core u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .go                (go),
        .rx_byte           (rx_byte),
        .max_frame_bytes   (max_frame_reg),
        .max_message_bytes (max_message_reg),
        .res_valid         (res_valid),
        .res               (res)
    );

    wscd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .res_valid (res_valid),
        .res       (res),
        .out_stall (out_stall),
        .busy      (busy),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign out_kind       = out_res.kind;
    assign payload_byte   = out_res.payload_byte;
    assign frame_opcode   = out_res.frame_opcode;
    assign message_opcode = out_res.message_opcode;
    assign end_of_frame   = out_res.end_of_frame;
    assign end_of_message = out_res.end_of_message;
    assign error_code     = out_res.error_code;

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wscd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam result_t NIL = '0;

    typedef struct packed {
        logic [7:0] rx;
        logic       known;
        result_t    want;
    } step_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  out_kind;
    logic [7:0]  payload_byte;
    logic [3:0]  frame_opcode;
    logic [3:0]  message_opcode;
    logic        end_of_frame;
    logic        end_of_message;
    logic [2:0]  error_code;

    websocket_client_frame_decoder dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_kind       (out_kind),
        .payload_byte   (payload_byte),
        .frame_opcode   (frame_opcode),
        .message_opcode (message_opcode),
        .end_of_frame   (end_of_frame),
        .end_of_message (end_of_message),
        .error_code     (error_code)
    );

    // deframer shadow state
    phase_t      ph           = PH_HDR0;
    logic [2:0]  hdr_idx      = '0;
    logic        fin_bit      = 1'b0;
    logic [3:0]  frame_op     = '0;
    logic [63:0] left         = '0;
    logic [31:0] key          = '0;
    logic [1:0]  key_pos      = '0;
    logic        msg_open     = 1'b0;
    logic [3:0]  msg_first_op = '0;
    logic [63:0] msg_total    = '0;
    logic [31:0] frame_lim    = MAX_FRAME_RESET;
    logic [31:0] msg_lim      = MAX_MESSAGE_RESET;

    result_t pending [$];
    int      mismatches  = 0;
    int      results_seen = 0;
    int      stall_mark  = 0;
    int      bytes_sent  = 0;
    int      frames_sent = 0;
    int      cycle_count = 0;
    int      out_hold    = 0;
    bit      steady      = 1'b0;
    string   close_cause = "nothing";

    // ping, empty; text opening a message, all-ones key; reserved data opcode with
    // a non-minimal 16-bit length restarting the message
    step_t directed_steps [23] = '{
        '{8'h89, 1'b0, NIL},
        '{8'h80, 1'b0, NIL},
        '{8'h00, 1'b0, NIL},
        '{8'h00, 1'b0, NIL},
        '{8'h00, 1'b0, NIL},
        '{8'h00, 1'b1, '{KIND_EMPTY, 8'h00, 4'h9, 4'h9, 1'b1, 1'b0, ERR_NONE}},
        '{8'h01, 1'b0, NIL},
        '{8'h82, 1'b0, NIL},
        '{8'hFF, 1'b0, NIL},
        '{8'hFF, 1'b0, NIL},
        '{8'hFF, 1'b0, NIL},
        '{8'hFF, 1'b0, NIL},
        '{8'hFF, 1'b1, '{KIND_PAYLOAD, 8'h00, 4'h1, 4'h1, 1'b0, 1'b0, ERR_NONE}},
        '{8'h00, 1'b1, '{KIND_PAYLOAD, 8'hFF, 4'h1, 4'h1, 1'b1, 1'b0, ERR_NONE}},
        '{8'h83, 1'b0, NIL},
        '{8'hFE, 1'b0, NIL},
        '{8'h00, 1'b0, NIL},
        '{8'h01, 1'b0, NIL},
        '{8'h12, 1'b0, NIL},
        '{8'h34, 1'b0, NIL},
        '{8'h56, 1'b0, NIL},
        '{8'h78, 1'b0, NIL},
        '{8'h5A, 1'b0, NIL}
    };

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("websocket_client_frame_decoder verification failed");
            $finish;
        end
    end

    function automatic result_t fault(err_t code);
        result_t r;
        r = '0;
        r.kind = KIND_ERROR;
        r.frame_opcode = frame_op;
        r.error_code = code;
        ph = PH_CLOSED;
        return r;
    endfunction

    // returns end of message
    function automatic logic end_frame();
        ph = PH_HDR0;
        if (frame_op[3])
        begin
            if (frame_op == OP_CLOSE)
                ph = PH_CLOSED;
            return 1'b0;
        end
        if (!fin_bit)
            return 1'b0;
        msg_open = 1'b0;
        msg_total = '0;
        return 1'b1;
    endfunction

    function automatic logic length_done(output result_t r);
        r = '0;
        if (left > 64'(frame_lim))
        begin
            r = fault(ERR_FRAME_SIZE);
            return 1'b1;
        end
        ph = PH_MASK;
        hdr_idx = '0;
        key = '0;
        return 1'b0;
    endfunction

    function automatic logic key_done(output result_t r);
        r = '0;
        if (frame_op[3])
        begin
            if (!fin_bit)
            begin
                r = fault(ERR_CTRL_FRAG);
                return 1'b1;
            end
            if (left > 64'(CTRL_MAX_LEN))
            begin
                r = fault(ERR_CTRL_SIZE);
                return 1'b1;
            end
        end
        else if (frame_op != OP_CONT)
        begin
            msg_open = 1'b1;
            msg_first_op = frame_op;
            msg_total = left;
        end
        else
        begin
            if (!msg_open)
            begin
                r = fault(ERR_STRAY_CONT);
                return 1'b1;
            end
            if (msg_total + left > 64'(msg_lim))
            begin
                r = fault(ERR_MSG_SIZE);
                return 1'b1;
            end
            msg_total = msg_total + left;
        end
        key_pos = '0;
        if (left != 64'd0)
        begin
            ph = PH_DATA;
            return 1'b0;
        end
        r.kind = KIND_EMPTY;
        r.frame_opcode = frame_op;
        r.message_opcode = frame_op[3] ? frame_op : msg_first_op;
        r.end_of_frame = 1'b1;
        r.end_of_message = end_frame();
        return 1'b1;
    endfunction

    task automatic decode_byte(input logic [7:0] b, output logic got, output result_t r);
        logic [7:0] kb;
        got = 1'b0;
        r = '0;
        case (ph)
            PH_HDR0:
            begin
                fin_bit = b[7];
                frame_op = b[3:0];
                ph = PH_HDR1;
            end
            PH_HDR1:
            begin
                if (!b[7])
                begin
                    r = fault(ERR_UNMASKED);
                    got = 1'b1;
                end
                else
                begin
                    left = '0;
                    hdr_idx = '0;
                    if (b[6:0] == LEN_EXT16)
                        ph = PH_EXT16;
                    else if (b[6:0] == LEN_EXT64)
                        ph = PH_EXT64;
                    else
                    begin
                        left = 64'(b[6:0]);
                        got = length_done(r);
                    end
                end
            end
            PH_EXT16, PH_EXT64:
            begin
                left = {left[55:0], b};
                if (hdr_idx == ((ph == PH_EXT16) ? EXT16_LAST : EXT64_LAST))
                    got = length_done(r);
                else
                    hdr_idx = hdr_idx + 3'd1;
            end
            PH_MASK:
            begin
                key = {key[23:0], b};
                if (hdr_idx >= MASK_LAST)
                    got = key_done(r);
                else
                    hdr_idx = hdr_idx + 3'd1;
            end
            PH_DATA:
            begin
                kb = 8'(key >> (8 * (3 - int'(key_pos))));
                key_pos = key_pos + 2'd1;
                if (left != 64'd0)
                    left = left - 64'd1;
                r.kind = KIND_PAYLOAD;
                r.payload_byte = b ^ kb;
                r.frame_opcode = frame_op;
                r.message_opcode = frame_op[3] ? frame_op : msg_first_op;
                if (left == 64'd0)
                begin
                    r.end_of_frame = 1'b1;
                    r.end_of_message = end_frame();
                end
                got = 1'b1;
            end
            default:
            begin
                ph = PH_CLOSED;
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        result_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result: expected none, got kind %0d byte %02h",
                         $time, out_kind, payload_byte);
            end
            else
            begin
                w = pending[0];
                pending.delete(0);
                if (out_kind !== w.kind || payload_byte !== w.payload_byte
                    || frame_opcode !== w.frame_opcode || message_opcode !== w.message_opcode
                    || end_of_frame !== w.end_of_frame || end_of_message !== w.end_of_message
                    || error_code !== w.error_code)
                begin
                    mismatches++;
                    $display({"%0t: mismatch: expected kind %0d byte %02h fop %h mop %h",
                              " eof %b eom %b err %0d"},
                             $time, w.kind, w.payload_byte, w.frame_opcode, w.message_opcode,
                             w.end_of_frame, w.end_of_message, w.error_code);
                    $display({"%0t:           actual kind %0d byte %02h fop %h mop %h",
                              " eof %b eom %b err %0d"},
                             $time, out_kind, payload_byte, frame_opcode, message_opcode,
                             end_of_frame, end_of_message, error_code);
                end
            end
        end
    end

    // a new hold is drawn after every accepted result
    always @(negedge clk)
    begin
        if (results_seen != stall_mark)
        begin
            stall_mark = results_seen;
            out_hold = steady ? 0 : $urandom_range(0, 4);
        end
        if (out_hold > 0)
        begin
            out_stall <= 1'b1;
            out_hold--;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send_byte(input logic [7:0] b, input logic known = 1'b0,
                             input result_t want = '0);
        int      gap;
        logic    got;
        result_t r;
        gap = steady ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (in_stall);
        decode_byte(b, got, r);
        if (known)
            pending = {pending, want};
        else if (got)
            pending = {pending, r};
        bytes_sent++;
    endtask

    task automatic send_frame(input logic fin, input logic [3:0] op, input logic [63:0] len,
                              input int ext, input logic masked, input int body);
        logic [31:0] k;
        k = $urandom;
        frames_sent++;
        send_byte({fin, 3'($urandom_range(0, 7)), op});
        case (ext)
            0: send_byte({masked, len[6:0]});
            1:
            begin
                send_byte({masked, LEN_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default:
            begin
                send_byte({masked, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8 * i +: 8]);
            end
        endcase
        for (int i = 3; i >= 0; i--)
            send_byte(k[8 * i +: 8]);
        repeat (body) send_byte(8'($urandom));
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic set_reg(input logic [0:0] idx, input logic [31:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_FRAME)
            frame_lim = v;
        else
            msg_lim = v;
    endtask

    // well-formed frame that stays inside the current limits
    task automatic random_frame();
        logic [63:0] cap;
        logic [63:0] len;
        logic [3:0]  op;
        logic        fin;
        int          pick;
        int          ext;
        steady = ($urandom_range(0, 5) == 0);
        pick = $urandom_range(0, 9);
        if (pick < 3)
        begin
            op = 4'($urandom_range(9, 15));
            fin = 1'b1;
            cap = (frame_lim < CTRL_MAX_LEN) ? 64'(frame_lim) : 64'(CTRL_MAX_LEN);
        end
        else if (msg_open && pick < 7 && msg_total <= 64'(msg_lim))
        begin
            op = OP_CONT;
            fin = 1'($urandom_range(0, 1));
            cap = 64'(msg_lim) - msg_total;
            if (cap > 64'(frame_lim))
                cap = 64'(frame_lim);
        end
        else
        begin
            op = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(3, 7))
                                              : 4'($urandom_range(1, 2));
            fin = 1'($urandom_range(0, 1));
            cap = 64'(frame_lim);
        end
        if (cap > 64'd300)
            cap = 64'd300;
        case ($urandom_range(0, 7))
            0: len = cap;
            1: len = 64'($urandom_range(0, 32'(cap)));
            default: len = 64'($urandom_range(0, (cap < 64'd24) ? 32'(cap) : 24));
        endcase
        if (len > 64'd125)
            ext = ($urandom_range(0, 3) == 0) ? 2 : 1;
        else
            ext = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
        send_frame(fin, op, len, ext, 1'b1, int'(len));
        if ($urandom_range(0, 24) == 0)
            drain();
    endtask

    task automatic run_frames(input int n);
        int target;
        target = bytes_sent + n;
        while (bytes_sent < target)
            random_frame();
    endtask

    // the block closes for good here: one error or a close frame, then dropped bytes
    task automatic close_out();
        logic [63:0] len;
        int          a;
        int          lo;
        drain();
        set_reg(CFG_MAX_FRAME, 32'($urandom_range(130, 400)));
        set_reg(CFG_MAX_MESSAGE, 32'($urandom_range(0, 120)));
        a = $urandom_range(0, 3);
        send_frame(1'b1, 4'($urandom_range(1, 2)), 64'(a), 0, 1'b1, a);
        case ($urandom_range(0, 6))
            0:
            begin
                close_cause = "a close frame";
                a = $urandom_range(0, 20);
                send_frame(1'b1, OP_CLOSE, 64'(a), 0, 1'b1, a);
            end
            1:
            begin
                close_cause = "an unmasked frame";
                send_frame(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                           64'($urandom_range(0, 125)), 0, 1'b0, 3);
            end
            2:
            begin
                close_cause = "an oversized frame";
                if ($urandom_range(0, 1))
                    len = 64'(frame_lim) + 64'($urandom_range(1, 1000));
                else
                    len = {32'($urandom), 32'($urandom)} | 64'h1_0000_0000;
                send_frame(1'b1, 4'($urandom_range(1, 2)), len,
                           (len > 64'd65535) ? 2 : $urandom_range(1, 2), 1'b1, 2);
            end
            3:
            begin
                close_cause = "a fragmented control frame";
                send_frame(1'b0, 4'($urandom_range(8, 15)), 64'($urandom_range(0, 125)), 0,
                           1'b1, 2);
            end
            4:
            begin
                close_cause = "an oversized control frame";
                send_frame(1'b1, 4'($urandom_range(8, 15)),
                           64'($urandom_range(126, int'(frame_lim))), 1, 1'b1, 2);
            end
            5:
            begin
                close_cause = "an oversized message";
                a = $urandom_range(0, 60);
                send_frame(1'b0, 4'($urandom_range(1, 2)), 64'(a), 0, 1'b1, a);
                lo = (int'(msg_lim) >= a) ? int'(msg_lim) - a + 1 : 0;
                len = 64'($urandom_range(lo, int'(frame_lim)));
                send_frame(1'($urandom_range(0, 1)), OP_CONT, len,
                           (len > 64'd125) ? 1 : 0, 1'b1, 2);
            end
            default:
            begin
                close_cause = "a stray continuation";
                send_frame(1'($urandom_range(0, 1)), OP_CONT, 64'($urandom_range(0, 10)), 0,
                           1'b1, 2);
            end
        endcase
        repeat (20) send_byte(8'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
            send_byte(directed_steps[i].rx, directed_steps[i].known, directed_steps[i].want);

        drain();
        set_reg(CFG_MAX_FRAME, 32'h0000_0000);
        set_reg(CFG_MAX_MESSAGE, 32'h0000_0000);
        run_frames(200);

        drain();
        set_reg(CFG_MAX_FRAME, 32'hFFFF_FFFF);
        set_reg(CFG_MAX_MESSAGE, 32'hFFFF_FFFF);
        run_frames(600);

        drain();
        set_reg(CFG_MAX_FRAME, 32'($urandom_range(0, 300)));
        set_reg(CFG_MAX_MESSAGE, 32'($urandom_range(0, 600)));
        run_frames(800);

        close_out();
        drain();
        repeat (8) @(posedge clk);

        $display("Decoded %0d bytes in %0d frames under five limit settings, %0d results.",
                 bytes_sent, frames_sent, results_seen);
        $display("Connection was shut by %s; trailing bytes were dropped.", close_cause);
        if (mismatches == 0 && pending.size() == 0)
            $display("websocket_client_frame_decoder verification clean");
        else
            $display("websocket_client_frame_decoder verification failed");
        $finish;
    end

endmodule
